// File: hdl/pia_pkg.sv
package pia_pkg;

    localparam logic [7:0] TYPE_LO  = 8'h0D;
    localparam logic [7:0] TYPE_HI  = 8'h14;
    localparam logic [7:0] WIDTH_LO = 8'h0D;
    localparam logic [7:0] WIDTH_HI = 8'h14;
    localparam logic [7:0] INT_BASE = 8'h0C;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_SIZE    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_OFFSET = 8'd1;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_TYPE  = 3'd1,
        ERR_WIDTH = 3'd2,
        ERR_COUNT = 3'd3,
        ERR_END   = 3'd4
    } err_code_t;

    typedef struct packed {
        logic [63:0] value;
        logic        last_element;
        logic        empty_array;
        err_code_t   error_code;
    } result_t;

endpackage

// File: hdl/pia_skid.sv
module pia_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pia_pkg::result_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pia_pkg::result_t  out_data
);
    import pia_pkg::*;

    logic    head_valid_reg;
    result_t head_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!head_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                head_valid_reg <= 1'b1;
                skid_valid_reg <= in_valid;
            end
            else
            begin
                head_valid_reg <= in_valid;
            end
        end
        else if (in_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!head_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                head_data_reg <= skid_data_reg;
                skid_data_reg <= in_data;
            end
            else
            begin
                head_data_reg <= in_data;
            end
        end
        else if (in_valid)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// File: hdl/packed_int_array_decoder.sv
// Packed integer array decoder.
// s_* : one blob byte per transfer (s_tdata). Arrays follow each other with no gap:
//       type byte, little-endian count, width byte, little-endian elements.
// m_* : one transfer per finished element, per empty array and per fault.
//       m_tdata is the element, m_tlast ends an array, m_tuser flags empty/error.
// cfg : data_size (index 0) and start_offset (index 1); write while idle.
//       start_offset is sampled on the first byte after reset.
// Throughput: one byte per cycle while s_tready is high. Each byte is decoded in the
// cycle it is taken and its result, if any, passes through the output register to m_*.
// A two-entry output register lets bytes keep flowing while a result waits;
// s_tready drops only while both entries are held by a stalled receiver.
// Reset clears all decode state and empties both registers; the first byte is then a
// type byte. After a fault one error transfer is sent and every later byte is
// taken and dropped until the next reset.
module packed_int_array_decoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [63:0]                      m_tdata,   // [63:0] value
    output logic                             m_tlast,   // last_element
    output logic [3:0]                       m_tuser,   // [0] empty_array, [3:1] error_code
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pia_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [31:0]                      cfg_data
);
    import pia_pkg::*;

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_COUNT,
        PH_WIDTH,
        PH_ELEM
    } phase_t;

    phase_t      phase_reg,         phase_next;
    logic [3:0]  bytes_left_reg,    bytes_left_next;
    logic [2:0]  byte_shift_reg,    byte_shift_next;
    logic [63:0] acc_reg,           acc_next;
    logic [63:0] elems_left_reg,    elems_left_next;
    logic [3:0]  elem_width_reg,    elem_width_next;
    logic [32:0] pos_reg,           pos_next;
    logic        halted_reg,        halted_next;
    logic        started_reg,       started_next;
    logic [31:0] data_size_reg;
    logic [31:0] start_offset_reg;

    logic        in_fire;
    logic        res_valid;
    logic        res_ready;
    result_t     res;
    result_t     out_res;

    logic [32:0] p;
    logic [63:0] acc_or;
    logic        p_past_end;
    logic        count_end;
    logic        elem_end;
    logic [3:0]  w_new;
    logic [63:0] count_m1;
    logic [34:0] count_prod;
    logic        count_too_large;

    assign cfg_ready = 1'b1;
    assign s_tready  = res_ready;
    assign in_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_size_reg    <= '0;
            start_offset_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DATA_SIZE:    data_size_reg    <= cfg_data;
                CFG_START_OFFSET: start_offset_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign p          = started_reg ? pos_reg : {1'b0, start_offset_reg};
    assign acc_or     = acc_reg | (64'(s_tdata) << {byte_shift_reg, 3'b000});
    assign p_past_end = p >= {1'b0, data_size_reg};
    assign count_end  = ({1'b0, p} + 34'(bytes_left_reg)) > {2'b00, data_size_reg};
    assign elem_end   = ({1'b0, p} + 34'(elem_width_reg)) > {2'b00, data_size_reg};
    assign w_new      = 4'(s_tdata - INT_BASE);
    assign count_m1   = elems_left_reg - 64'd1;
    // count > size/w + 1  <=>  (count - 1) * w > size, for count >= 1
    assign count_prod = 35'(count_m1[31:0]) * 35'(w_new);
    assign count_too_large = (elems_left_reg != 64'd0) &&
                             ((count_m1[63:32] != 32'd0) ||
                              (count_prod > {3'b000, data_size_reg}));

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        byte_shift_next = byte_shift_reg;
        acc_next        = acc_reg;
        elems_left_next = elems_left_reg;
        elem_width_next = elem_width_reg;
        pos_next        = pos_reg;
        halted_next     = halted_reg;
        started_next    = started_reg;
        res_valid       = 1'b0;
        res.value        = '0;
        res.last_element = 1'b0;
        res.empty_array  = 1'b0;
        res.error_code   = ERR_NONE;

        if (in_fire && !halted_reg)
        begin
            started_next = 1'b1;
            pos_next     = p + 33'd1;
            case (phase_reg)
                PH_TYPE:
                begin
                    if (p_past_end)
                        res.error_code = ERR_END;
                    else if (s_tdata < TYPE_LO || s_tdata > TYPE_HI)
                        res.error_code = ERR_TYPE;
                    else
                    begin
                        bytes_left_next = w_new;
                        byte_shift_next = '0;
                        acc_next        = '0;
                        phase_next      = PH_COUNT;
                    end
                end
                PH_COUNT:
                begin
                    if (byte_shift_reg == 3'd0 && count_end)
                        res.error_code = ERR_END;
                    else
                    begin
                        acc_next        = acc_or;
                        byte_shift_next = byte_shift_reg + 3'd1;
                        bytes_left_next = bytes_left_reg - 4'd1;
                        if (bytes_left_reg == 4'd1)
                        begin
                            elems_left_next = acc_or;
                            phase_next      = PH_WIDTH;
                        end
                    end
                end
                PH_WIDTH:
                begin
                    if (p_past_end)
                        res.error_code = ERR_END;
                    else if (s_tdata < WIDTH_LO || s_tdata > WIDTH_HI)
                        res.error_code = ERR_WIDTH;
                    else if (count_too_large)
                        res.error_code = ERR_COUNT;
                    else
                    begin
                        elem_width_next = w_new;
                        if (elems_left_reg == 64'd0)
                        begin
                            res_valid        = 1'b1;
                            res.last_element = 1'b1;
                            res.empty_array  = 1'b1;
                            phase_next       = PH_TYPE;
                        end
                        else
                        begin
                            bytes_left_next = w_new;
                            byte_shift_next = '0;
                            acc_next        = '0;
                            phase_next      = PH_ELEM;
                        end
                    end
                end
                default:
                begin
                    if (byte_shift_reg == 3'd0 && bytes_left_reg == elem_width_reg && elem_end)
                        res.error_code = ERR_END;
                    else
                    begin
                        acc_next        = acc_or;
                        byte_shift_next = byte_shift_reg + 3'd1;
                        bytes_left_next = bytes_left_reg - 4'd1;
                        if (bytes_left_reg == 4'd1)
                        begin
                            elems_left_next  = count_m1;
                            res_valid        = 1'b1;
                            res.value        = acc_or;
                            res.last_element = (elems_left_reg == 64'd1);
                            if (elems_left_reg == 64'd1)
                                phase_next = PH_TYPE;
                            else
                            begin
                                bytes_left_next = elem_width_reg;
                                byte_shift_next = '0;
                                acc_next        = '0;
                            end
                        end
                    end
                end
            endcase

            if (res.error_code != ERR_NONE)
            begin
                res_valid   = 1'b1;
                halted_next = 1'b1;
                pos_next    = pos_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TYPE;
            bytes_left_reg <= '0;
            byte_shift_reg <= '0;
            acc_reg        <= '0;
            elems_left_reg <= '0;
            elem_width_reg <= '0;
            pos_reg        <= '0;
            halted_reg     <= 1'b0;
            started_reg    <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            byte_shift_reg <= byte_shift_next;
            acc_reg        <= acc_next;
            elems_left_reg <= elems_left_next;
            elem_width_reg <= elem_width_next;
            pos_reg        <= pos_next;
            halted_reg     <= halted_next;
            started_reg    <= started_next;
        end
    end

    pia_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = out_res.value;
    assign m_tlast = out_res.last_element;
    assign m_tuser = {out_res.error_code, out_res.empty_array};

    a_no_result_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !res_valid)
        else $error("result produced while halted");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.error_code != ERR_NONE |=> halted_reg)
        else $error("error result did not halt decoder");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");

    a_empty_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.empty_array |->
            res.last_element && res.value == 64'd0 && res.error_code == ERR_NONE)
        else $error("malformed empty-array result");

    a_elem_phase_width: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ELEM |-> elem_width_reg != 4'd0 && elems_left_reg != 64'd0)
        else $error("element phase without width or count");

endmodule

// File: bench/packed_int_array_decoder_tb.sv
module packed_int_array_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pia_pkg::*;

    typedef enum logic [1:0] {
        WANT_TYPE,
        WANT_COUNT,
        WANT_WIDTH,
        WANT_ELEM
    } dec_field_t;

    typedef enum {
        FILL_RANDOM,
        FILL_ZEROS,
        FILL_ONES
    } fill_t;

    typedef enum {
        FLT_TYPE,
        FLT_WIDTH,
        FLT_COUNT,
        FLT_TYPE_END,
        FLT_COUNT_END,
        FLT_WIDTH_END,
        FLT_ELEM_END
    } fault_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = 8'd0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [63:0]            m_tdata;
    logic                   m_tlast;
    logic [3:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data = 32'd0;

    // decoder copy
    logic [31:0] size_reg = 32'd0;
    logic [31:0] offset_reg = 32'd0;
    dec_field_t  dec_field = WANT_TYPE;
    logic [3:0]  dec_left = 4'd0;
    logic [2:0]  dec_shift = 3'd0;
    logic [63:0] dec_acc = 64'd0;
    logic [63:0] dec_elems = 64'd0;
    logic [3:0]  dec_width = 4'd0;
    logic [32:0] dec_pos = 33'd0;
    bit          dec_halted = 1'b0;
    bit          dec_started = 1'b0;

    result_t expected_elements[$];

    bit          src_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          hold_len = 0;
    int          hold_seq = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    int          mismatches = 0;
    int          bytes_sent = 0;
    int          arrays_sent = 0;
    int          results_seen = 0;
    int          empties_predicted = 0;
    int          input_stalls = 0;
    logic [31:0] first_offset = 32'd0;
    fault_t      fault_seen = FLT_TYPE;

    packed_int_array_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        #(5_000_000);
        $display("packed_int_array_decoder regression: fail");
        $finish;
    end

    function automatic void take_byte(input logic [7:0] b);
        dec_acc   |= 64'(b) << (8 * dec_shift);
        dec_shift += 3'd1;
        dec_left  -= 4'd1;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        logic [63:0] p;
        logic [63:0] size64;
        err_code_t   err;
        result_t     r;
        bit          emit;
        if (dec_halted)
            return;
        if (!dec_started)
        begin
            dec_pos     = {1'b0, offset_reg};
            dec_started = 1'b1;
        end
        p      = 64'(dec_pos);
        size64 = 64'(size_reg);
        err    = ERR_NONE;
        emit   = 1'b0;
        r      = '0;
        case (dec_field)
            WANT_TYPE:
            begin
                if (p >= size64)
                    err = ERR_END;
                else if (b < TYPE_LO || b > TYPE_HI)
                    err = ERR_TYPE;
                else
                begin
                    dec_left  = 4'(b - INT_BASE);
                    dec_shift = 3'd0;
                    dec_acc   = 64'd0;
                    dec_field = WANT_COUNT;
                end
            end
            WANT_COUNT:
            begin
                if (dec_shift == 3'd0 && p + 64'(dec_left) > size64)
                    err = ERR_END;
                else
                begin
                    take_byte(b);
                    if (dec_left == 4'd0)
                    begin
                        dec_elems = dec_acc;
                        dec_field = WANT_WIDTH;
                    end
                end
            end
            WANT_WIDTH:
            begin
                if (p >= size64)
                    err = ERR_END;
                else if (b < WIDTH_LO || b > WIDTH_HI)
                    err = ERR_WIDTH;
                else
                begin
                    dec_width = 4'(b - INT_BASE);
                    if (dec_elems > size64 / 64'(dec_width) + 64'd1)
                        err = ERR_COUNT;
                    else if (dec_elems == 64'd0)
                    begin
                        emit           = 1'b1;
                        r.last_element = 1'b1;
                        r.empty_array  = 1'b1;
                        dec_field      = WANT_TYPE;
                        empties_predicted++;
                    end
                    else
                    begin
                        dec_left  = dec_width;
                        dec_shift = 3'd0;
                        dec_acc   = 64'd0;
                        dec_field = WANT_ELEM;
                    end
                end
            end
            default:
            begin
                if (dec_shift == 3'd0 && dec_left == dec_width &&
                    p + 64'(dec_width) > size64)
                    err = ERR_END;
                else
                begin
                    take_byte(b);
                    if (dec_left == 4'd0)
                    begin
                        dec_elems      -= 64'd1;
                        emit           = 1'b1;
                        r.value        = dec_acc;
                        r.last_element = (dec_elems == 64'd0);
                        if (dec_elems == 64'd0)
                            dec_field = WANT_TYPE;
                        else
                        begin
                            dec_left  = dec_width;
                            dec_shift = 3'd0;
                            dec_acc   = 64'd0;
                        end
                    end
                end
            end
        endcase
        if (err != ERR_NONE)
        begin
            dec_halted   = 1'b1;
            r            = '0;
            r.error_code = err;
            expected_elements = {expected_elements, r};
            return;
        end
        dec_pos = 33'(p + 64'd1);
        if (emit)
            expected_elements = {expected_elements, r};
    endfunction

    // result check
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            got.value        = m_tdata;
            got.last_element = m_tlast;
            got.empty_array  = m_tuser[0];
            got.error_code   = err_code_t'(m_tuser[3:1]);
            if (expected_elements.size() == 0)
            begin
                if (mismatches < 10)
                    $display("result %0d with none outstanding: value %h last %b empty %b code %0d",
                             results_seen, got.value, got.last_element, got.empty_array,
                             got.error_code);
                mismatches++;
            end
            else
            begin
                want = expected_elements.pop_front();
                if (got.value !== want.value || got.last_element !== want.last_element ||
                    got.empty_array !== want.empty_array ||
                    got.error_code !== want.error_code)
                begin
                    if (mismatches < 10)
                        $display({"result %0d: got value %h last %b empty %b code %0d,",
                                  " wanted value %h last %b empty %b code %0d"},
                                 results_seen, got.value, got.last_element, got.empty_array,
                                 got.error_code, want.value, want.last_element,
                                 want.empty_array, want.error_code);
                    mismatches++;
                end
            end
            results_seen++;
        end
    end

    // receiver pacing and long holds
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= hold_len;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= !rx_idle_on || ($urandom_range(99) >= 35);
    end

    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (src_idle_on)
            while ($urandom_range(99) < 35 && gap < 12)
                gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
        begin
            input_stalls++;
            @(posedge clk);
        end
        decode_byte(b);
        bytes_sent++;
    endtask

    // sender goes quiet until every outstanding result has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_elements.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_DATA_SIZE)
            size_reg = val;
        else if (idx == CFG_START_OFFSET)
            offset_reg = val;
        @(posedge clk);
    endtask

    task automatic send_count(input int unsigned cw, input logic [63:0] count);
        for (int i = 0; i < cw; i++)
            push_byte(8'(count >> (8 * i)));
    endtask

    task automatic send_array(input int unsigned cw, input int unsigned ew,
                              input logic [63:0] count, input fill_t fill);
        logic [7:0] b;
        push_byte(INT_BASE + 8'(cw));
        send_count(cw, count);
        push_byte(INT_BASE + 8'(ew));
        for (longint unsigned e = 0; e < count; e++)
            for (int i = 0; i < ew; i++)
            begin
                case (fill)
                    FILL_ZEROS: b = 8'h00;
                    FILL_ONES:  b = 8'hFF;
                    default:    b = 8'($urandom_range(0, 255));
                endcase
                push_byte(b);
            end
        arrays_sent++;
    endtask

    task automatic send_random_array();
        int unsigned cw;
        int unsigned ew;
        int unsigned pick;
        int unsigned count;
        cw   = $urandom_range(1, 8);
        ew   = $urandom_range(1, 8);
        pick = $urandom_range(99);
        if (pick < 10)
            count = 0;
        else if (pick < 85)
            count = $urandom_range(1, 4);
        else
            count = $urandom_range(5, 12);
        send_array(cw, ew, 64'(count), FILL_RANDOM);
    endtask

    function automatic logic [7:0] outside_range(input logic [7:0] lo, input logic [7:0] hi);
        if ($urandom_range(0, 1))
            return 8'($urandom_range(0, lo - 1));
        return 8'($urandom_range(hi + 1, 255));
    endfunction

    task automatic test_reset_config();
        write_reg(CFG_DATA_SIZE, 32'hFFFF_FFFF);
        write_reg(CFG_INDEX_W'($urandom_range(2, 255)), $urandom());
        first_offset = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(0, 32'hFFFF_0000);
        write_reg(CFG_START_OFFSET, first_offset);
    endtask

    task automatic test_field_extremes();
        send_array(1, 8, 1, FILL_ONES);
        send_array(1, 1, 1, FILL_ZEROS);
        send_array(8, 1, 0, FILL_RANDOM);
    endtask

    // offset is latched on the first byte; later writes must not move position
    task automatic test_late_offset();
        wait_drained();
        write_reg(CFG_START_OFFSET, 32'hFFFF_FFFF);
        write_reg(CFG_DATA_SIZE, 32'd0);
        write_reg(CFG_DATA_SIZE, 32'hFFFF_FFFF);
        write_reg(CFG_INDEX_W'($urandom_range(2, 255)), $urandom());
        repeat (3) send_random_array();
        wait_drained();
        write_reg(CFG_START_OFFSET, 32'd0);
        repeat (2) send_random_array();
    endtask

    // blob size set so the array ends exactly at, or just short of, the limit
    task automatic test_exact_fit();
        int unsigned cw;
        int unsigned ew;
        int unsigned count;
        int unsigned slack;
        repeat (4)
        begin
            cw    = $urandom_range(1, 8);
            ew    = $urandom_range(1, 8);
            count = $urandom_range(0, 4);
            slack = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
            wait_drained();
            write_reg(CFG_DATA_SIZE, dec_pos[31:0] + 32'(2 + cw + count * ew + slack));
            send_array(cw, ew, 64'(count), FILL_RANDOM);
        end
        wait_drained();
        write_reg(CFG_DATA_SIZE, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_traffic(input int n);
        int stop_at;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at)
        begin
            send_random_array();
            if ($urandom_range(11) == 0)
                wait_drained();
        end
    endtask

    task automatic test_no_idle(input int n);
        int stop_at;
        stop_at     = bytes_sent + n;
        src_idle_on = 1'b0;
        rx_idle_on  = 1'b0;
        while (bytes_sent < stop_at)
            send_random_array();
        src_idle_on = 1'b1;
        rx_idle_on  = 1'b1;
    endtask

    // receiver stalls while short elements keep coming, so the output fills
    task automatic test_backpressure();
        wait_drained();
        src_idle_on = 1'b0;
        hold_len    = 300;
        hold_seq++;
        repeat (6) send_array(1, 1, 8, FILL_RANDOM);
        src_idle_on = 1'b1;
        wait_drained();
    endtask

    // one fault per run (the block halts until reset), kind chosen at random
    task automatic test_fault();
        fault_t      kind;
        int unsigned cw;
        int unsigned ew;
        int unsigned k;
        logic [31:0] here;
        logic [63:0] too_many;
        kind = fault_t'($urandom_range(0, 6));
        cw   = $urandom_range(1, 8);
        ew   = $urandom_range(1, 8);
        k    = $urandom_range(0, 3);
        wait_drained();
        here = dec_pos[31:0];
        case (kind)
            FLT_TYPE:
                push_byte(outside_range(TYPE_LO, TYPE_HI));
            FLT_WIDTH:
            begin
                push_byte(INT_BASE + 8'(cw));
                send_count(cw, 64'(k));
                push_byte(outside_range(WIDTH_LO, WIDTH_HI));
            end
            FLT_COUNT:
            begin
                write_reg(CFG_DATA_SIZE, here + 32'd64);
                too_many = 64'(here + 32'd64) / 64'(ew) + 64'd1 + 64'($urandom_range(1, 3));
                push_byte(INT_BASE + 8'd8);
                send_count(8, too_many);
                push_byte(INT_BASE + 8'(ew));
            end
            FLT_TYPE_END:
            begin
                write_reg(CFG_DATA_SIZE, $urandom_range(0, 1) ? 32'd0 : here);
                push_byte(INT_BASE + 8'(cw));
            end
            FLT_COUNT_END:
            begin
                write_reg(CFG_DATA_SIZE, here + 32'd1 + $urandom_range(0, cw - 1));
                push_byte(INT_BASE + 8'(cw));
                send_count(cw, 64'(k));
            end
            FLT_WIDTH_END:
            begin
                write_reg(CFG_DATA_SIZE, here + 32'(1 + cw));
                push_byte(INT_BASE + 8'(cw));
                send_count(cw, 64'(k));
                push_byte(INT_BASE + 8'(ew));
            end
            default:
            begin
                write_reg(CFG_DATA_SIZE, here + 32'(2 + cw + k * ew) + $urandom_range(0, ew - 1));
                send_array(cw, ew, 64'(k + 1), FILL_RANDOM);
            end
        endcase
        // halted: these are taken and dropped
        repeat (8) push_byte(8'($urandom_range(0, 255)));
        fault_seen = kind;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_config();
        test_field_extremes();
        test_late_offset();
        test_exact_fit();
        test_random_traffic(600);
        test_no_idle(250);
        test_backpressure();
        test_random_traffic(100);
        test_fault();
        wait_drained();
        repeat (10) @(posedge clk);
        $display("sent %0d bytes in %0d arrays, checked %0d results (%0d empty), %0d input stalls",
                 bytes_sent, arrays_sent, results_seen, empties_predicted, input_stalls);
        $display("start offset %h, run closed by a %s fault", first_offset, fault_seen.name());
        if (mismatches == 0 && expected_elements.size() == 0)
            $display("packed_int_array_decoder regression: pass");
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatches, expected_elements.size());
            $display("packed_int_array_decoder regression: fail");
        end
        $finish;
    end

endmodule
